// ----- sv/s2l_pkg.sv -----
`default_nettype none
package s2l_pkg;

    localparam int LAB_FRAC_BITS = 7;
    localparam int GAIN_W        = 17;
    localparam int LIN_W         = 17;
    localparam int T_W           = 18;
    localparam int ROOT_W        = 17;
    localparam int RAD_W         = 51;
    localparam int LAB_L_W       = 14;
    localparam int LAB_AB_W      = 15;

    // config register indexes
    localparam logic [1:0] REG_INV_WHITE_X = 2'd0;
    localparam logic [1:0] REG_INV_WHITE_Y = 2'd1;
    localparam logic [1:0] REG_INV_WHITE_Z = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd65536;

    // sRGB to XYZ matrix, units of 1/10000, [row][column]
    typedef logic [13:0] t_coef_row [3];
    typedef t_coef_row   t_coef_mat [3];
    localparam t_coef_mat MAT = '{
        '{14'd4124, 14'd3576, 14'd1805},
        '{14'd2126, 14'd7152, 14'd722},
        '{14'd193,  14'd1192, 14'd9505}
    };

    // reciprocals for constant division
    localparam logic [31:0] RECIP_10000  = 32'd3518437209;   // ceil(2^45/10000)
    localparam int          SHIFT_10000  = 45;
    localparam logic [31:0] RECIP_116000 = 32'd2426508421;   // ceil(2^48/116000)
    localparam int          SHIFT_116000 = 48;
    localparam logic [31:0] HALF_SCALE   = 32'd327680000;
    localparam logic [19:0] LIN_SLOPE    = 20'd903292;       // 7787*116
    localparam logic [30:0] LIN_OFFSET   = 31'd1048634000;   // 16*65536*1000 + 58000
    localparam logic [T_W-1:0] CBRT_MIN_T = 18'd581;         // t*1e6 > 8856*65536

    typedef logic [LIN_W-1:0] t_lin_rom [256];

    function automatic longint unsigned f_pow5(input longint unsigned y);
        longint unsigned y2;
        longint unsigned y4;
        y2 = (y * y) >> 16;
        y4 = (y2 * y2) >> 16;
        return (y4 * y) >> 16;
    endfunction

    function automatic t_lin_rom f_build_lin();
        t_lin_rom rom;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        for (int v = 0; v < 256; v++) begin
            if (longint'(v) * 100000 <= 1031475) begin
                rom[v] = LIN_W'((longint'(v) * 6553600 + 164730) / 329460);
            end else begin
                u  = ((longint'(v) * 1000 + 14025) * 65536 + 134512) / 269025;
                u2 = (u * u + 32768) >> 16;
                lo = 0;
                hi = 65536;
                while (lo < hi) begin
                    mid = (lo + hi + 1) / 2;
                    if (f_pow5(mid) <= u2) lo = mid;
                    else hi = mid - 1;
                end
                rom[v] = LIN_W'((u2 * lo + 32768) >> 16);
            end
        end
        return rom;
    endfunction

    localparam t_lin_rom LIN_ROM = f_build_lin();

endpackage
`default_nettype wire

// ----- sv/s2l_cbrt.sv -----
`default_nettype none
// Pipelined floor cube root, one 3-bit radicand group per stage.
module s2l_cbrt
    import s2l_pkg::*;
#(
    parameter int P_SIDE_W = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [RAD_W-1:0]    i_rad,
    input  wire logic [P_SIDE_W-1:0] i_side,
    output logic      [ROOT_W-1:0]   o_root,
    output logic      [P_SIDE_W-1:0] o_side
);

    localparam int NG  = RAD_W / 3;
    localparam int RW  = 2 * ROOT_W + 3;
    localparam int QW  = 2 * ROOT_W;
    localparam int CW  = RW + 3;

    logic [ROOT_W-1:0]   r_s    [NG];
    logic [QW-1:0]       r_q    [NG];
    logic [RW-1:0]       r_r    [NG];
    logic [RAD_W-1:0]    r_x    [NG];
    logic [P_SIDE_W-1:0] r_side [NG];

    for (genvar k = 0; k < NG; k++) begin : g_stage
        logic [ROOT_W-1:0]   p_s;
        logic [QW-1:0]       p_q;
        logic [RW-1:0]       p_r;
        logic [RAD_W-1:0]    p_x;
        logic [P_SIDE_W-1:0] p_side;
        logic [CW-1:0]       rr;
        logic [CW-1:0]       d;
        logic [ROOT_W-1:0]   s2;
        logic [QW-1:0]       q4;
        logic                take;

        if (k == 0) begin : g_first
            assign p_s    = '0;
            assign p_q    = '0;
            assign p_r    = '0;
            assign p_x    = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_s    = r_s[k-1];
            assign p_q    = r_q[k-1];
            assign p_r    = r_r[k-1];
            assign p_x    = r_x[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            rr   = {p_r, p_x[RAD_W-1 -: 3]};
            s2   = {p_s[ROOT_W-2:0], 1'b0};
            q4   = {p_q[QW-3:0], 2'b00};
            d    = CW'(q4) * CW'(3) + CW'(s2) * CW'(3) + CW'(1);
            take = (rr >= d);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k]    <= take ? (s2 | ROOT_W'(1)) : s2;
                r_q[k]    <= take ? (q4 + QW'({s2, 1'b0}) + QW'(1)) : q4;
                r_r[k]    <= take ? RW'(rr - d) : RW'(rr);
                r_x[k]    <= p_x << 3;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_root = r_s[NG-1];
    assign o_side = r_side[NG-1];

endmodule
`default_nettype wire

// ----- sv/srgb_to_cielab.sv -----
`default_nettype none
// srgb_to_cielab: sRGB pixel in, CIELAB L*, a*, b* out.
//
// Slave stream (s_axis) takes one pixel word per cycle when not stalled;
// tdata holds red, green, blue in bits [7:0], [15:8], [23:16]. Master
// stream (m_axis) gives one Lab word per pixel: lightness [13:0],
// green_red [28:14], blue_yellow [43:29], zero padded to 48 bits. Lab
// values carry P_LAB_FRAC_BITS fraction bits and saturate at their field limits.
//
// Throughput is one pixel per cycle while the receiver does not stall.
// Depth is set by the cube root, which resolves one root bit per stage
// over 17 stages, plus 9 front stages (table, matrix, white gain,
// divide-by-constant multiplies) and one output stage.
//
// The cfg port writes the reciprocal reference white gains (Q16, reset
// 65536 = white 100). Writes to unused indexes are dropped. Write only
// while the pipeline is empty.
//
// Reset empties the pipeline and restores the gains. When the receiver
// stalls with a word waiting, the whole pipeline holds; bubbles in
// flight keep o_s_axis_tready high until the output word is stuck.
module srgb_to_cielab
    import s2l_pkg::*;
#(
    parameter int P_LAB_FRAC_BITS = LAB_FRAC_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [23:0]       i_s_axis_tdata,   // red, green, blue
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [47:0]            o_m_axis_tdata,   // lightness, green_red, blue_yellow
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [GAIN_W-1:0] i_cfg_data
);

    localparam int NFRONT = 9;
    localparam int NCBRT  = RAD_W / 3;
    localparam int NST    = NFRONT + NCBRT + 1;
    localparam int SH     = 16 - P_LAB_FRAC_BITS;
    localparam int VW     = 28;
    localparam int SIDE_W = 16;

    logic [GAIN_W-1:0] r_gain [3];
    logic [NST-1:0]    r_vld;
    logic              en;

    assign en              = !r_vld[NST-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[NST-1];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= GAIN_RESET;
            r_gain[1] <= GAIN_RESET;
            r_gain[2] <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INV_WHITE_X: r_gain[0] <= i_cfg_data;
                REG_INV_WHITE_Y: r_gain[1] <= i_cfg_data;
                REG_INV_WHITE_Z: r_gain[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_s_axis_tvalid};
        end
    end

    // front stages, per channel / axis
    logic [LIN_W-1:0]       r_lin  [3];
    logic [29:0]            r_sum  [3];
    logic [46:0]            r_prod [3];
    logic [31:0]            r_a    [3];
    logic [63:0]            r_q    [3];
    logic [T_W-1:0]         r_t6   [3];
    logic [30:0]            r_n    [3];
    logic [T_W-1:0]         r_t7   [3];
    logic [62:0]            r_q2   [3];
    logic [T_W-1:0]         r_t8   [3];
    logic [14:0]            r_flin [3];
    logic                   r_sel  [3];
    logic [T_W-1:0]         r_t9   [3];
    logic [ROOT_W-1:0]      root   [3];
    logic [SIDE_W-1:0]      side   [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lin[0] <= LIN_ROM[i_s_axis_tdata[7:0]];
            r_lin[1] <= LIN_ROM[i_s_axis_tdata[15:8]];
            r_lin[2] <= LIN_ROM[i_s_axis_tdata[23:16]];
            for (int i = 0; i < 3; i++) begin
                r_sum[i]  <= 30'(r_lin[0]) * 30'(MAT[i][0])
                           + 30'(r_lin[1]) * 30'(MAT[i][1])
                           + 30'(r_lin[2]) * 30'(MAT[i][2]);
                r_prod[i] <= 47'(r_sum[i]) * 47'(r_gain[i]);
                // round(p / (10000*2^16)): shift first, then divide by 10000
                r_a[i]    <= 32'((r_prod[i] + 47'(HALF_SCALE)) >> 16);
                r_q[i]    <= 64'(r_a[i]) * 64'(RECIP_10000);
                r_t6[i]   <= T_W'(r_q[i] >> SHIFT_10000);
                // linear segment numerator; only used while t is small
                r_n[i]    <= 31'(r_t6[i][9:0]) * 31'(LIN_SLOPE) + LIN_OFFSET;
                r_t7[i]   <= r_t6[i];
                r_q2[i]   <= 63'(r_n[i]) * 63'(RECIP_116000);
                r_t8[i]   <= r_t7[i];
                r_flin[i] <= 15'(r_q2[i] >> SHIFT_116000);
                r_sel[i]  <= (r_t8[i] >= CBRT_MIN_T);
                r_t9[i]   <= r_t8[i];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_cbrt
        s2l_cbrt #(
            .P_SIDE_W (SIDE_W)
        ) u_cbrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rad  ({1'b0, r_t9[i], 32'd0}),
            .i_side ({r_sel[i], r_flin[i]}),
            .o_root (root[i]),
            .o_side (side[i])
        );
    end

    // output stage: f select, Lab formulas, rounding, saturation
    function automatic logic signed [VW-1:0] f_round(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] half;
        half = VW'(1) <<< (SH - 1);
        if (v >= 0) return (v + half) >>> SH;
        return -((-v + half) >>> SH);
    endfunction

    logic signed [VW-1:0] f      [3];
    logic signed [VW-1:0] lv;
    logic signed [VW-1:0] av;
    logic signed [VW-1:0] bv;
    logic [LAB_L_W-1:0]   l_sat;
    logic [LAB_AB_W-1:0]  a_sat;
    logic [LAB_AB_W-1:0]  b_sat;
    logic [47:0]          r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f[i] = side[i][15] ? VW'(root[i]) : VW'(side[i][14:0]);
        end
        lv = f_round(f[1] * VW'(116) - VW'(1048576));
        av = f_round((f[0] - f[1]) * VW'(500));
        bv = f_round((f[1] - f[2]) * VW'(200));
        if (lv < 0)                  l_sat = '0;
        else if (lv > VW'(16383))    l_sat = LAB_L_W'(16383);
        else                         l_sat = LAB_L_W'(lv);
        if (av < -VW'(16384))        a_sat = LAB_AB_W'(16384);
        else if (av > VW'(16383))    a_sat = LAB_AB_W'(16383);
        else                         a_sat = LAB_AB_W'(av);
        if (bv < -VW'(16384))        b_sat = LAB_AB_W'(16384);
        else if (bv > VW'(16383))    b_sat = LAB_AB_W'(16383);
        else                         b_sat = LAB_AB_W'(bv);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {4'b0, b_sat, a_sat, l_sat};
        end
    end

    assign o_m_axis_tdata = r_out;

endmodule
`default_nettype wire

// ----- sv/s2l_checker.sv -----
`default_nettype none
module s2l_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [47:0] o_m_axis_tdata
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed under stall");

    // nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // input side only blocks when a word is stuck at the output
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

    // pad bits stay clear
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[47:44] == 4'b0)
        else $error("padding bits set");

endmodule

bind srgb_to_cielab s2l_checker u_s2l_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

// ----- sim/srgb_to_cielab_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module srgb_to_cielab_tb;
    import s2l_pkg::*;

    // Lab word as the block packs it: lightness, green_red, blue_yellow
    typedef struct packed {
        logic [LAB_AB_W-1:0] blue_yellow;
        logic [LAB_AB_W-1:0] green_red;
        logic [LAB_L_W-1:0]  lightness;
    } t_lab;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [23:0]       i_s_axis_tdata = '0;   // red, green, blue
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [47:0]       o_m_axis_tdata;        // lightness, green_red, blue_yellow
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = '0;
    logic [GAIN_W-1:0] i_cfg_data = '0;

    srgb_to_cielab dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    localparam int PIPE_DRAIN = 40;   // margin over the pipeline latency

    // predictor state: linearization table and white gains
    longint unsigned    lin_tab [256];
    logic [GAIN_W-1:0]  gain_x = GAIN_RESET;
    logic [GAIN_W-1:0]  gain_y = GAIN_RESET;
    logic [GAIN_W-1:0]  gain_z = GAIN_RESET;

    t_lab lab_pending [$];   // expected Lab words, oldest first
    int   mismatches = 0;
    bit   failed = 1'b0;
    int   send_idle = 0;     // percent of cycles the sender holds back
    int   recv_idle = 0;     // percent of cycles the receiver stalls

    // Q16 y^5 with truncation after each product
    function automatic longint unsigned fifth_pow(longint unsigned y);
        longint unsigned sq;
        longint unsigned quad;
        sq   = (y * y) >> 16;
        quad = (sq * sq) >> 16;
        return (quad * y) >> 16;
    endfunction

    // sRGB transfer curve into Q16, gamma 2.4 as u^2 * u^(2/5)
    function automatic longint unsigned linearize(int code);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (longint'(code) * 100000 <= 1031475)
            return (longint'(code) * 6553600 + 164730) / 329460;
        u  = ((longint'(code) * 1000 + 14025) * 65536 + 134512) / 269025;
        u2 = (u * u + 32768) >> 16;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (fifth_pow(mid) <= u2) lo = mid;
            else hi = mid - 1;
        end
        return (u2 * lo + 32768) >> 16;
    endfunction

    // CIE f(): cube root above the knee, linear segment below
    function automatic longint cie_curve(longint unsigned t);
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (t * 1000000 > 64'd8856 * 65536) begin
            target = t << 32;
            lo = 0;
            hi = 64'd1 << 18;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (mid * mid * mid <= target) lo = mid;
                else hi = mid - 1;
            end
            return longint'(lo);
        end
        return longint'((t * 7787 * 116 + 64'd16 * 65536 * 1000 + 58000) / 116000);
    endfunction

    // Q16 down to Lab fraction bits, half away from zero
    function automatic longint to_lab_frac(longint v);
        int     sh;
        longint half;
        sh   = 16 - LAB_FRAC_BITS;
        half = longint'(1) << (sh - 1);
        if (v >= 0) return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_lab srgb_to_lab(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        longint          fx;
        longint          fy;
        longint          fz;
        t_lab            lab;
        r  = lin_tab[r8];
        g  = lin_tab[g8];
        b  = lin_tab[b8];
        fx = cie_curve(((r * 4124 + g * 3576 + b * 1805) * gain_x + 327680000) / 655360000);
        fy = cie_curve(((r * 2126 + g * 7152 + b * 722) * gain_y + 327680000) / 655360000);
        fz = cie_curve(((r * 193 + g * 1192 + b * 9505) * gain_z + 327680000) / 655360000);
        lab.lightness   = LAB_L_W'(clip(to_lab_frac(116 * fy - 16 * 65536), 0, 16383));
        lab.green_red   = LAB_AB_W'(clip(to_lab_frac(500 * (fx - fy)), -16384, 16383));
        lab.blue_yellow = LAB_AB_W'(clip(to_lab_frac(200 * (fy - fz)), -16384, 16383));
        return lab;
    endfunction

    // send one pixel word; the expectation is queued at acceptance
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, g, r};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        lab_pending.push_back(srgb_to_lab(r, g, b));
    endtask

    // let the pipeline empty, with valid low
    task automatic drain_pipe();
        int guard;
        guard = 0;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (lab_pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // register write while idle; index 3 is not a register and is dropped
    task automatic write_gain(logic [1:0] idx, logic [GAIN_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_INV_WHITE_X: gain_x = val;
            REG_INV_WHITE_Y: gain_y = val;
            REG_INV_WHITE_Z: gain_z = val;
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [GAIN_W-1:0] gx, logic [GAIN_W-1:0] gy,
                             logic [GAIN_W-1:0] gz);
        drain_pipe();
        write_gain(REG_INV_WHITE_X, gx);
        write_gain(REG_INV_WHITE_Y, gy);
        write_gain(REG_INV_WHITE_Z, gz);
    endtask

    // receiver: random stalls, and compare of each accepted Lab word
    always @(posedge i_clk) begin
        t_lab got;
        t_lab want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_lab'(o_m_axis_tdata[43:0]);
            if (lab_pending.size() == 0) begin
                failed = 1'b1;
                if (mismatches < 10) $display("unexpected Lab word %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = lab_pending.pop_front();
                if (got !== want || o_m_axis_tdata[47:44] !== 4'd0) begin
                    failed = 1'b1;
                    if (mismatches < 10)
                        $display("Lab mismatch: L %0d/%0d a %0d/%0d b %0d/%0d (exp/got)",
                                 want.lightness, got.lightness,
                                 $signed(want.green_red), $signed(got.green_red),
                                 $signed(want.blue_yellow), $signed(got.blue_yellow));
                    mismatches++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // corner pixels: black, white, primaries, knee of the transfer curve
    task automatic test_corner_pixels();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd10, 8'd10, 8'd10);
        send_pixel(8'd11, 8'd11, 8'd11);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h55, 8'hAA, 8'h55);
    endtask

    // extreme gains: zero (flat f), full scale (t above 1), unknown index
    task automatic test_gain_extremes();
        set_gains('0, '0, '0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd200, 8'd30, 8'd90);
        set_gains('1, '1, '1);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0);
        set_gains('1, '0, 17'd65536);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd255);
        drain_pipe();
        write_gain(2'd3, 17'd12345);
        send_pixel(8'd90, 8'd180, 8'd45);
        set_gains(GAIN_RESET, GAIN_RESET, GAIN_RESET);
    endtask

    task automatic test_random_pixels(int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int n = 0; n < count; n++) begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            // some near-black and near-gray pixels to work the low end
            if ($urandom_range(9) == 0) begin
                r = 8'($urandom_range(16));
                g = 8'($urandom_range(16));
                b = 8'($urandom_range(16));
            end else if ($urandom_range(9) == 0) begin
                g = r;
                b = r;
            end
            send_pixel(r, g, b);
        end
    endtask

    task automatic test_random_gains(int count);
        set_gains(17'($urandom_range(131071)), 17'($urandom_range(131071)),
                  17'($urandom_range(131071)));
        test_random_pixels(count);
        set_gains(17'($urandom_range(50000, 80000)), 17'($urandom_range(50000, 80000)),
                  17'($urandom_range(50000, 80000)));
        test_random_pixels(count);
    endtask

    initial begin
        for (int v = 0; v < 256; v++) lin_tab[v] = linearize(v);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 7;
        recv_idle = 73;
        test_corner_pixels();
        test_gain_extremes();
        test_random_pixels(150);
        test_random_gains(75);

        send_idle = 73;
        recv_idle = 7;
        test_random_pixels(150);
        test_random_gains(75);

        send_idle = 0;
        recv_idle = 0;
        set_gains(GAIN_RESET, GAIN_RESET, GAIN_RESET);
        test_random_pixels(150);
        test_random_gains(75);

        drain_pipe();
        if (!failed && lab_pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
